### hw/rtl/fji_pkg.sv
// Shared types, constants and saturation helpers for the Jacobian inverse block.
package fji_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DW          = 32;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned NUM_ENT     = 9;
  localparam int unsigned ENT_W       = $clog2(NUM_ENT + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DVD_W       = DW + FRAC_BITS;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  typedef logic signed [DW-1:0] q_t;
  typedef logic [ENT_W-1:0]     ent_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DET = 2'd1,
    ST_NEG_DET  = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    q_t   grad_x;
    q_t   grad_y;
    q_t   grad_z;
    q_t   coord_x;
    q_t   coord_y;
    q_t   coord_z;
    logic last_node;
  } in_t;

  typedef struct packed {
    q_t         determinant;
    q_t         inv_t_00;
    q_t         inv_t_01;
    q_t         inv_t_02;
    q_t         inv_t_10;
    q_t         inv_t_11;
    q_t         inv_t_12;
    q_t         inv_t_20;
    q_t         inv_t_21;
    q_t         inv_t_22;
    logic [1:0] status;
  } out_t;

  // One finished cell: 32-bit Jacobian entries, row-major
  typedef struct packed {
    q_t [NUM_ENT-1:0] jac;
    logic [1:0]       dim;
    logic             sat;
  } cell_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } satq_t;

  typedef struct packed {
    logic start;
    q_t   num;
    q_t   den;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quo;
    logic sat;
  } div_rsp_t;

  // Clamp a wide signed value to 32 bits
  function automatic satq_t sat32(input logic signed [63:0] v);
    satq_t r;
    r.sat = 1'b0;
    if (v > Q_MAX) begin
      r.val = Q_MAX[DW-1:0];
      r.sat = 1'b1;
    end else if (v < Q_MIN) begin
      r.val = Q_MIN[DW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DW-1:0];
    end
    return r;
  endfunction

  // True when entry idx (row-major 3x3) lies inside the active dimension
  function automatic logic ent_used(input ent_t idx, input logic [1:0] dim);
    logic [1:0] row;
    logic [1:0] col;
    row = 2'd0;
    col = 2'd0;
    case (idx)
      ent_t'(0): begin row = 2'd0; col = 2'd0; end
      ent_t'(1): begin row = 2'd0; col = 2'd1; end
      ent_t'(2): begin row = 2'd0; col = 2'd2; end
      ent_t'(3): begin row = 2'd1; col = 2'd0; end
      ent_t'(4): begin row = 2'd1; col = 2'd1; end
      ent_t'(5): begin row = 2'd1; col = 2'd2; end
      ent_t'(6): begin row = 2'd2; col = 2'd0; end
      ent_t'(7): begin row = 2'd2; col = 2'd1; end
      ent_t'(8): begin row = 2'd2; col = 2'd2; end
      default: begin row = 2'd3; col = 2'd3; end
    endcase
    return (row < dim) && (col < dim);
  endfunction

endpackage

### hw/rtl/fem_jacobian_inverse.sv
// Top level of the isoparametric Jacobian determinant and inverse block.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------
//  in        | input     | in_valid_i / in_ready_o  | in_data_i  (in_t)
//  out       | output    | out_valid_o / out_ready_i| out_data_o (out_t)
//  cfg       | input     | cfg_we_i                 | cfg_data_i (dimension)
//
// A node passes the front end as intake with multiply, then accumulate;
// the last node of a cell adds a push state that hands the cell to a 2-entry queue.
// The back end per cell runs its products on its one multiplier (2 for 2D,
// 21 for 3D), then one serial division per used inverse entry. Reset clears the
// accumulators and sets the dimension to 3. The front stalls only while the
// queue is full; the back stalls only while the result register is occupied.
module fem_jacobian_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fji_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fji_pkg::out_t out_data_o
);
  import fji_pkg::*;

  logic     [1:0] dim_q;
  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  cell_t          push_data;
  cell_t          q_data;
  div_req_t       div_req;
  div_rsp_t       div_rsp;

  // Dimension register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= 2'd3;
    end else if (cfg_we_i) begin
      dim_q <= cfg_data_i;
    end
  end

  fji_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  fji_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  fji_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fji_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cell_i      (q_data),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hw/rtl/fji_front.sv
// Front end: node intake, nine multiply-accumulates, cell snapshot into the queue.
module fji_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     dim_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fji_pkg::in_t   in_data_i,
  output logic           push_o,
  output fji_pkg::cell_t push_data_o,
  input  logic           full_i
);
  import fji_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_ACC, F_PUSH} fstate_e;

  localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [63:0] ACC_MIN = -(64'sd1 <<< (ACC_W - 1));

  fstate_e                  state_q;
  logic signed [63:0]       prod_q [NUM_ENT];
  logic signed [63:0]       prod_d [NUM_ENT];
  logic                     use_q  [NUM_ENT];
  logic signed [ACC_W-1:0]  acc_q  [NUM_ENT];
  logic signed [ACC_W-1:0]  acc_d  [NUM_ENT];
  logic                     acc_ovf[NUM_ENT];
  logic                     last_q;
  logic [1:0]               dim_q;
  logic                     sat_q;
  logic                     acc_flag;
  logic                     jac_flag;
  q_t                       g [3];
  q_t                       c [3];

  assign g[0] = in_data_i.grad_x;
  assign g[1] = in_data_i.grad_y;
  assign g[2] = in_data_i.grad_z;
  assign c[0] = in_data_i.coord_x;
  assign c[1] = in_data_i.coord_y;
  assign c[2] = in_data_i.coord_z;

  // J(r,k) term: grad_k * coord_r
  for (genvar gi = 0; gi < NUM_ENT; gi++) begin : g_mul
    assign prod_d[gi] = g[gi % 3] * c[gi / 3];
  end

  // Floor-shift products and saturating 48-bit accumulate
  always_comb begin
    logic signed [63:0] sum;
    acc_flag = 1'b0;
    for (int i = 0; i < NUM_ENT; i++) begin
      sum = 64'(acc_q[i]) + (prod_q[i] >>> FRAC_BITS);
      acc_ovf[i] = 1'b0;
      if (sum > ACC_MAX) begin
        acc_d[i]   = ACC_MAX[ACC_W-1:0];
        acc_ovf[i] = 1'b1;
      end else if (sum < ACC_MIN) begin
        acc_d[i]   = ACC_MIN[ACC_W-1:0];
        acc_ovf[i] = 1'b1;
      end else begin
        acc_d[i] = sum[ACC_W-1:0];
      end
      if (use_q[i] && acc_ovf[i]) acc_flag = 1'b1;
    end
  end

  // Snapshot of the finished cell, clamped to 32 bits
  always_comb begin
    satq_t s;
    jac_flag = 1'b0;
    for (int i = 0; i < NUM_ENT; i++) begin
      s = sat32(64'(acc_q[i]));
      if (ent_used(ent_t'(i), dim_q)) begin
        push_data_o.jac[i] = s.val;
        if (s.sat) jac_flag = 1'b1;
      end else begin
        push_data_o.jac[i] = '0;
      end
    end
    push_data_o.dim = dim_q;
    push_data_o.sat = sat_q | jac_flag;
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  // Product register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      for (int i = 0; i < NUM_ENT; i++) prod_q[i] <= prod_d[i];
    end
  end

  // Control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      last_q  <= 1'b0;
      dim_q   <= 2'd0;
      sat_q   <= 1'b0;
      for (int i = 0; i < NUM_ENT; i++) begin
        acc_q[i] <= '0;
        use_q[i] <= 1'b0;
      end
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            last_q <= in_data_i.last_node;
            dim_q  <= dim_i;
            for (int i = 0; i < NUM_ENT; i++) use_q[i] <= ent_used(ent_t'(i), dim_i);
            state_q <= F_ACC;
          end
        end
        F_ACC: begin
          for (int i = 0; i < NUM_ENT; i++) begin
            if (use_q[i]) acc_q[i] <= acc_d[i];
          end
          sat_q   <= sat_q | acc_flag;
          state_q <= last_q ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!full_i) begin
            for (int i = 0; i < NUM_ENT; i++) acc_q[i] <= '0;
            sat_q   <= 1'b0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/fji_fifo.sv
// Short register queue of finished cells between front and back end.
module fji_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fji_pkg::cell_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fji_pkg::cell_t data_o
);
  import fji_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cell_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/fji_div.sv
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, clamped to 32 bits.
module fji_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fji_pkg::div_req_t req_i,
  output fji_pkg::div_rsp_t rsp_o
);
  import fji_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] MAG_NEG_LIM = DVD_W'(1) << (DW - 1);
  localparam logic [DVD_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - 1'b1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DW-1:0]    dsr_q;
  logic             neg_q;
  logic [DW:0]      rem_sh;
  logic             ge;
  logic [DW:0]      rem_sub;
  logic [DW-1:0]    num_mag;
  logic [DW-1:0]    den_mag;

  assign num_mag = req_i.num[DW-1] ? DW'(-req_i.num) : DW'(req_i.num);
  assign den_mag = req_i.den[DW-1] ? DW'(-req_i.den) : DW'(req_i.den);

  // One quotient bit per cycle
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  // Sign and clamp of the quotient held in dvd_q
  always_comb begin
    rsp_o.done = done_q;
    rsp_o.sat  = 1'b0;
    if (neg_q) begin
      if (dvd_q > MAG_NEG_LIM) begin
        rsp_o.quo = Q_MIN[DW-1:0];
        rsp_o.sat = 1'b1;
      end else begin
        rsp_o.quo = DW'(-dvd_q);
      end
    end else if (dvd_q > MAG_POS_LIM) begin
      rsp_o.quo = Q_MAX[DW-1:0];
      rsp_o.sat = 1'b1;
    end else begin
      rsp_o.quo = dvd_q[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        rem_q  <= '0;
        dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
        dsr_q  <= den_mag;
        neg_q  <= req_i.num[DW-1] ^ req_i.den[DW-1];
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/fji_back.sv
// Back end: cofactors and determinant on a shared multiplier, divisions, result register.
module fji_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fji_pkg::cell_t    cell_i,
  output logic              pop_o,
  output fji_pkg::div_req_t div_req_o,
  input  fji_pkg::div_rsp_t div_rsp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fji_pkg::out_t     out_data_o
);
  import fji_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_ADD, B_DIVSEL, B_DIVRUN, B_DONE} bstate_e;

  localparam int unsigned S_W = 5;
  localparam logic [S_W-1:0] STEP_DET3  = S_W'(18);
  localparam logic [S_W-1:0] STEP_LAST3 = S_W'(20);
  localparam logic [S_W-1:0] STEP_LAST2 = S_W'(1);
  localparam logic [ENT_W-1:0] ENT_END  = ENT_W'(NUM_ENT);
  localparam q_t ONE_Q = q_t'(64'sd1 <<< FRAC_BITS);

  bstate_e            state_q;
  q_t                 j_q   [NUM_ENT];
  q_t                 cof_q [NUM_ENT];
  q_t                 inv_q [NUM_ENT];
  q_t                 det_q;
  logic [1:0]         dim_q;
  logic               sat_q;
  logic [S_W-1:0]     s_q;
  ent_t               e_q;
  logic signed [63:0] t_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q;
  out_t               out_q;

  // Left operand of each product
  function automatic ent_t op_a(input logic [S_W-1:0] s, input logic [1:0] dim);
    ent_t r;
    if (dim != 2'd3) begin
      r = (s == '0) ? ent_t'(0) : ent_t'(1);
    end else begin
      case (s)
        S_W'(0), S_W'(4), S_W'(14), S_W'(17): r = ent_t'(3);
        S_W'(1), S_W'(6):                     r = ent_t'(7);
        S_W'(2), S_W'(5), S_W'(9), S_W'(10):  r = ent_t'(6);
        S_W'(3), S_W'(13):                    r = ent_t'(4);
        S_W'(7), S_W'(12), S_W'(19):          r = ent_t'(1);
        S_W'(8), S_W'(11), S_W'(15), S_W'(16), S_W'(18): r = ent_t'(0);
        S_W'(20):                             r = ent_t'(2);
        default:                              r = ent_t'(0);
      endcase
      if (s == S_W'(0)) r = ent_t'(4);
      if (s == S_W'(3)) r = ent_t'(3);
      if (s == S_W'(13)) r = ent_t'(4);
    end
    return r;
  endfunction

  // Right operand of each product (Jacobian entry; det steps use cofactors)
  function automatic ent_t op_b(input logic [S_W-1:0] s, input logic [1:0] dim);
    ent_t r;
    if (dim != 2'd3) begin
      r = (s == '0) ? ent_t'(4) : ent_t'(3);
    end else begin
      case (s)
        S_W'(0), S_W'(3), S_W'(7), S_W'(8):   r = ent_t'(8);
        S_W'(1), S_W'(2), S_W'(12), S_W'(15): r = ent_t'(5);
        S_W'(4), S_W'(11):                    r = ent_t'(7);
        S_W'(5), S_W'(16):                    r = ent_t'(4);
        S_W'(6), S_W'(9), S_W'(13), S_W'(14): r = ent_t'(2);
        S_W'(10), S_W'(17):                   r = ent_t'(1);
        S_W'(18):                             r = ent_t'(0);
        S_W'(19):                             r = ent_t'(1);
        S_W'(20):                             r = ent_t'(2);
        default:                              r = ent_t'(0);
      endcase
    end
    return r;
  endfunction

  logic               dim3;
  logic               det_step;
  q_t                 mul_a;
  q_t                 mul_b;
  logic signed [63:0] term;
  logic               first;
  logic               sub;
  logic signed [63:0] sum;
  satq_t              sum_sat;
  logic               cof_wr;
  logic               det_wr;
  satq_t              neg3;
  satq_t              neg1;
  logic [1:0]         status;
  logic               out_load;
  q_t                 cof_ld [NUM_ENT];
  q_t                 det_ld;
  logic               sat_ld;
  bstate_e            nxt_ld;

  assign dim3     = (dim_q == 2'd3);
  assign det_step = dim3 && (s_q >= STEP_DET3);
  assign mul_a    = j_q[op_a(s_q, dim_q)];
  assign mul_b    = det_step ? cof_q[ENT_W'(s_q - STEP_DET3)] : j_q[op_b(s_q, dim_q)];

  // Term combine: cofactor pairs subtract, 3D determinant terms add, 2D determinant subtracts
  always_comb begin
    term = prod_q >>> FRAC_BITS;
    if (dim3) begin
      first  = (s_q < STEP_DET3) ? !s_q[0] : (s_q == STEP_DET3);
      sub    = (s_q < STEP_DET3) && s_q[0];
      cof_wr = (s_q < STEP_DET3) && s_q[0];
      det_wr = (s_q == STEP_LAST3);
    end else begin
      first  = (s_q == '0);
      sub    = (s_q == STEP_LAST2);
      cof_wr = 1'b0;
      det_wr = (s_q == STEP_LAST2);
    end
    sum     = (first ? 64'sd0 : t_q) + (sub ? -term : term);
    sum_sat = sat32(sum);
  end

  // Negated entries for the 2D cofactors
  assign neg3 = sat32(-64'(cell_i.jac[3]));
  assign neg1 = sat32(-64'(cell_i.jac[1]));

  // Start values of a new cell by dimension
  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) cof_ld[i] = '0;
    det_ld = '0;
    sat_ld = cell_i.sat;
    nxt_ld = B_DIVSEL;
    case (cell_i.dim)
      2'd1: begin
        det_ld    = cell_i.jac[0];
        cof_ld[0] = ONE_Q;
      end
      2'd2: begin
        cof_ld[0] = cell_i.jac[4];
        cof_ld[1] = neg3.val;
        cof_ld[3] = neg1.val;
        cof_ld[4] = cell_i.jac[0];
        sat_ld    = cell_i.sat | neg3.sat | neg1.sat;
        nxt_ld    = B_MUL;
      end
      2'd3:    nxt_ld = B_MUL;
      default: nxt_ld = B_DIVSEL;
    endcase
  end

  // Result code
  always_comb begin
    if (det_q == '0)                 status = ST_ZERO_DET;
    else if (dim3 && det_q[DW-1])    status = ST_NEG_DET;
    else if (sat_q)                  status = ST_SAT;
    else                             status = ST_OK;
  end

  assign pop_o = (state_q == B_IDLE) && valid_i;
  assign out_load = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  assign div_req_o.start = (state_q == B_DIVSEL) && (det_q != '0) && (e_q < ENT_END) &&
                           ent_used(e_q, dim_q);
  assign div_req_o.num   = cof_q[e_q];
  assign div_req_o.den   = det_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Shared multiplier register
  always_ff @(posedge clk_i) begin
    if (state_q == B_MUL) prod_q <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      dim_q       <= 2'd0;
      sat_q       <= 1'b0;
      s_q         <= '0;
      e_q         <= '0;
      t_q         <= '0;
      det_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < NUM_ENT; i++) begin
        j_q[i]   <= '0;
        cof_q[i] <= '0;
        inv_q[i] <= '0;
      end
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            for (int i = 0; i < NUM_ENT; i++) begin
              j_q[i]   <= cell_i.jac[i];
              cof_q[i] <= cof_ld[i];
              inv_q[i] <= '0;
            end
            dim_q   <= cell_i.dim;
            sat_q   <= sat_ld;
            s_q     <= '0;
            e_q     <= '0;
            det_q   <= det_ld;
            state_q <= nxt_ld;
          end
        end
        B_MUL: state_q <= B_ADD;
        B_ADD: begin
          t_q <= sum;
          if (cof_wr) begin
            cof_q[ENT_W'(s_q >> 1)] <= sum_sat.val;
            sat_q <= sat_q | sum_sat.sat;
          end
          if (det_wr) begin
            det_q   <= sum_sat.val;
            sat_q   <= sat_q | sum_sat.sat;
            state_q <= B_DIVSEL;
          end else begin
            s_q     <= s_q + 1'b1;
            state_q <= B_MUL;
          end
        end
        B_DIVSEL: begin
          if ((det_q == '0) || (e_q >= ENT_END)) begin
            state_q <= B_DONE;
          end else if (ent_used(e_q, dim_q)) begin
            state_q <= B_DIVRUN;
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        B_DIVRUN: begin
          if (div_rsp_i.done) begin
            inv_q[e_q] <= div_rsp_i.quo;
            sat_q      <= sat_q | div_rsp_i.sat;
            e_q        <= e_q + 1'b1;
            state_q    <= B_DIVSEL;
          end
        end
        B_DONE: begin
          if (out_load) begin
            out_q.determinant <= det_q;
            out_q.inv_t_00    <= inv_q[0];
            out_q.inv_t_01    <= inv_q[1];
            out_q.inv_t_02    <= inv_q[2];
            out_q.inv_t_10    <= inv_q[3];
            out_q.inv_t_11    <= inv_q[4];
            out_q.inv_t_12    <= inv_q[5];
            out_q.inv_t_20    <= inv_q[6];
            out_q.inv_t_21    <= inv_q[7];
            out_q.inv_t_22    <= inv_q[8];
            out_q.status      <= status;
            state_q           <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> valid_i) else $error("cell taken from empty queue");
  a_div_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |=> (state_q == B_DIVRUN)) else $error("divider start not followed");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == B_IDLE))) else $error("result not registered");
  a_div_ret_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == B_DIVRUN)) else $error("quotient returned unexpectedly");
`endif

endmodule
